[rtl/ngc_pkg.sv]
package ngc_pkg;

  // Chunk position counter width and its saturation value
  localparam int POS_W = 17;
  localparam logic [POS_W-1:0] POS_CAP = {POS_W{1'b1}};

  // Gear table geometry
  localparam int GEAR_W   = 64;
  localparam int GEAR_AW  = 8;

  // Stream command codes carried on s_tuser
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_DATA = 1'b1;

  // Register indexes on the configuration port
  typedef enum logic [2:0] {
    REG_MIN_SIZE    = 3'd0,
    REG_NORMAL_SIZE = 3'd1,
    REG_MAX_SIZE    = 3'd2,
    REG_MASK_STRICT = 3'd3,
    REG_MASK_LOOSE  = 3'd4
  } cfg_reg_t;

  // Register reset values
  localparam logic [15:0]       MIN_SIZE_RST    = 16'd6144;
  localparam logic [POS_W-1:0]  NORMAL_SIZE_RST = POS_W'(8192);
  localparam logic [POS_W-1:0]  MAX_SIZE_RST    = POS_W'(32768);
  localparam logic [GEAR_W-1:0] MASK_STRICT_RST = 64'h0000_f907_0353_0000;
  localparam logic [GEAR_W-1:0] MASK_LOOSE_RST  = 64'h0000_d900_0353_0000;

  typedef struct packed {
    logic [15:0]       min_size;
    logic [POS_W-1:0]  normal_size;
    logic [POS_W-1:0]  max_size;
    logic [GEAR_W-1:0] mask_strict;
    logic [GEAR_W-1:0] mask_loose;
  } cfg_t;

  // One result: closed chunk length and final flag
  typedef struct packed {
    logic [POS_W-1:0] length;
    logic             last;
  } result_t;

  // Results pushed by the cut stage in one cycle (count 0..2, r0 first)
  typedef struct packed {
    logic [1:0] count;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage

[rtl/ngc_gear_ram.sv]
module ngc_gear_ram (
  input  logic                           clk,
  input  logic                           wr_en,
  input  logic [ngc_pkg::GEAR_AW-1:0]    wr_addr,
  input  logic [ngc_pkg::GEAR_W-1:0]     wr_data,
  input  logic                           rd_en,
  input  logic [ngc_pkg::GEAR_AW-1:0]    rd_addr,
  output logic [ngc_pkg::GEAR_W-1:0]     rd_data
);
  import ngc_pkg::*;

  logic [GEAR_W-1:0] mem [2**GEAR_AW];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port, holds while not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/ngc_cut_stage.sv]
module ngc_cut_stage (
  input  logic                       clk,
  input  logic                       rst,
  input  ngc_pkg::cfg_t              cfg,
  input  logic                       data_accept,
  input  logic                       data_last,
  input  logic [ngc_pkg::GEAR_W-1:0] gear_value,
  input  logic                       out_space,
  output logic                       in_ready,
  output ngc_pkg::push_t             push
);
  import ngc_pkg::*;

  logic              busy;
  logic              last_q;
  logic [GEAR_W-1:0] fp;
  logic [GEAR_W-1:0] fp_next;
  logic [POS_W-1:0]  pos;
  logic [POS_W-1:0]  pos_next;
  logic              advance;

  logic              pos_nz;
  logic              cut_max;
  logic              do_hash;
  logic [GEAR_W-1:0] fp_hash;
  logic [GEAR_W-1:0] mask;
  logic              cut_hash;
  logic              cut;
  logic [POS_W-1:0]  pos_base;
  logic [POS_W-1:0]  pos_inc;

  assign advance  = busy && out_space;
  assign in_ready = !busy || out_space;

  // Hash the byte, test for a cut, step the position
  always_comb begin
    pos_nz   = (pos != '0);
    cut_max  = pos_nz && (pos >= cfg.max_size);
    do_hash  = !cut_max && (pos >= {1'b0, cfg.min_size});
    fp_hash  = {fp[GEAR_W-2:0], 1'b0} + gear_value;
    mask     = (pos < cfg.normal_size) ? cfg.mask_strict : cfg.mask_loose;
    cut_hash = do_hash && pos_nz && ((fp_hash & mask) == '0);
    cut      = cut_max || cut_hash;
    pos_base = cut ? '0 : pos;
    pos_inc  = (pos_base == POS_CAP) ? pos_base : pos_base + POS_W'(1);

    if (last_q) begin
      fp_next = '0;
    end else if (cut) begin
      fp_next = (cfg.min_size == '0) ? gear_value : '0;
    end else if (do_hash) begin
      fp_next = fp_hash;
    end else begin
      fp_next = fp;
    end
    pos_next = last_q ? '0 : pos_inc;
  end

  // Assemble the results of this byte
  always_comb begin
    push.count = '0;
    push.r0    = '{length: pos_inc, last: 1'b1};
    push.r1    = '{length: pos_inc, last: 1'b1};
    if (advance) begin
      push.count = {1'b0, cut} + {1'b0, last_q};
      if (cut) begin
        push.r0 = '{length: pos, last: 1'b0};
      end
    end
  end

  // Stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (data_accept) begin
      busy <= 1'b1;
    end else if (advance) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (data_accept) begin
      last_q <= data_last;
    end
  end

  // Chunk state
  always_ff @(posedge clk) begin
    if (rst) begin
      fp  <= '0;
      pos <= '0;
    end else if (advance) begin
      fp  <= fp_next;
      pos <= pos_next;
    end
  end

endmodule

[rtl/ngc_out_fifo.sv]
module ngc_out_fifo (
  input  logic              clk,
  input  logic              rst,
  input  ngc_pkg::push_t    push,
  output logic              space,
  output logic              out_valid,
  input  logic              out_ready,
  output ngc_pkg::result_t  out_data
);
  import ngc_pkg::*;

  localparam int DEPTH = 4;
  localparam int AW    = $clog2(DEPTH);

  result_t         entries [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [AW:0]     count;
  logic            pop;
  logic [AW-1:0]   wr_ptr_1;

  assign space     = (count <= (AW+1)'(DEPTH - 2));
  assign out_valid = (count != '0);
  assign out_data  = entries[rd_ptr];
  assign pop       = out_valid && out_ready;
  assign wr_ptr_1  = wr_ptr + AW'(1);

  // Store up to two results
  always_ff @(posedge clk) begin
    if (push.count != '0) begin
      entries[wr_ptr] <= push.r0;
    end
    if (push.count == 2'd2) begin
      entries[wr_ptr_1] <= push.r1;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + AW'(push.count);
      if (pop) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      count <= count + (AW+1)'(push.count) - (AW+1)'(pop);
    end
  end

endmodule

[rtl/normalized_gear_chunker.sv]
// Channel   Direction  tdata fields (low bit up)                    tuser     tlast
// s_*       in         table_index[7:0] table_value[71:8]          command   end_of_data
//                      data_byte[79:72]
// m_*       out        chunk_length[16:0], zero fill to 24         -         final_chunk
// cfg_*     in         write enable, register index, 64-bit data    -         -
//
// One input transfer per cycle while the output queue has space. The gear table read is
// registered at the transfer edge, and the hash and cut stage pushes the byte's results
// into the output queue once it has space; they are then offered on m_*.
// A byte that both cuts and ends the stream yields two results; the output queue
// drains one per cycle while m_tready is high, so a run of such bytes backs the queue up
// to three entries, and then s_tready drops until the queue holds two or fewer.
// Reset (rst, synchronous) restores register defaults and clears chunk state;
// the gear table is not cleared and must be loaded before data.
// m_tready low fills the four-entry queue to three or more results and then stalls
// the input side, loads included.
module normalized_gear_chunker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [79:0] s_tdata,   // table_index, table_value, data_byte
  input  logic        s_tuser,   // command
  input  logic        s_tlast,   // end_of_data
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // chunk_length, zero fill
  output logic        m_tlast    // final_chunk
);
  import ngc_pkg::*;

  cfg_t              cfg;
  logic              accept;
  logic              load_accept;
  logic              data_accept;
  logic [GEAR_W-1:0] gear_value;
  logic              out_space;
  push_t             push;
  result_t           out_data;

  assign accept      = s_tvalid && s_tready;
  assign load_accept = accept && (s_tuser == CMD_LOAD);
  assign data_accept = accept && (s_tuser == CMD_DATA);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_size    <= MIN_SIZE_RST;
      cfg.normal_size <= NORMAL_SIZE_RST;
      cfg.max_size    <= MAX_SIZE_RST;
      cfg.mask_strict <= MASK_STRICT_RST;
      cfg.mask_loose  <= MASK_LOOSE_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_MIN_SIZE:    cfg.min_size    <= cfg_data[15:0];
        REG_NORMAL_SIZE: cfg.normal_size <= cfg_data[POS_W-1:0];
        REG_MAX_SIZE:    cfg.max_size    <= cfg_data[POS_W-1:0];
        REG_MASK_STRICT: cfg.mask_strict <= cfg_data;
        REG_MASK_LOOSE:  cfg.mask_loose  <= cfg_data;
        default: ;
      endcase
    end
  end

  ngc_gear_ram u_ram (
    .clk     (clk),
    .wr_en   (load_accept),
    .wr_addr (s_tdata[7:0]),
    .wr_data (s_tdata[71:8]),
    .rd_en   (data_accept),
    .rd_addr (s_tdata[79:72]),
    .rd_data (gear_value)
  );

  ngc_cut_stage u_cut (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .data_accept (data_accept),
    .data_last   (s_tlast),
    .gear_value  (gear_value),
    .out_space   (out_space),
    .in_ready    (s_tready),
    .push        (push)
  );

  ngc_out_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .space     (out_space),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_data)
  );

  assign m_tdata = {(24 - POS_W)'(0), out_data.length};
  assign m_tlast = out_data.last;

endmodule

[tb/tb_normalized_gear_chunker.sv]
`timescale 1ns / 1ps

module tb_normalized_gear_chunker;
  import ngc_pkg::*;

  localparam int HOLD_CYCLES   = 300;
  localparam int IDLE_LIMIT    = 3000;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASES        = 5;
  localparam int PHASE_ITEMS   = 235;

  typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

  // One directed step: a register write or a stream transfer
  typedef struct {
    row_kind_t   kind;
    cfg_reg_t    reg_idx;
    logic [63:0] reg_val;
    logic        cmd;
    logic [7:0]  idx;
    logic [63:0] val;
    logic [7:0]  dbyte;
    logic        eod;
    int          n_typed;   // -1: take the chunks from the predictor
    result_t     typed0;
    result_t     typed1;
  } dir_row_t;

  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_data;
  logic        s_tvalid;
  logic        s_tready;
  logic [79:0] s_tdata;   // table_index, table_value, data_byte
  logic        s_tuser;   // command
  logic        s_tlast;   // end_of_data
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;   // chunk_length, zero fill
  logic        m_tlast;   // final_chunk

  // Shadow copy of the chunker state and registers
  logic [63:0]      shadow_gear [256];
  logic [63:0]      shadow_fp;
  logic [POS_W-1:0] shadow_pos;
  cfg_t             shadow_cfg;

  result_t  pending_chunks [$];
  dir_row_t dir_rows [$];
  int       errors = 0;
  int       burst_left = 0;
  int       idle_cycles = 0;
  bit       hold_req = 1'b0;
  bit       hold_done = 1'b0;

  normalized_gear_chunker dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Advance the shadow state by one transfer; return the chunks it closes
  function automatic int gear_cut_step(input logic cmd, input logic [7:0] idx,
                                       input logic [63:0] val, input logic [7:0] dbyte,
                                       input logic eod, output result_t r0,
                                       output result_t r1);
    logic [POS_W-1:0] p;
    logic [63:0]      m;
    logic             cut;
    int               n;
    result_t          outs [2];
    p = shadow_pos;
    cut = 1'b0;
    n = 0;
    outs[0] = '0;
    outs[1] = '0;
    r0 = '0;
    r1 = '0;
    if (cmd == CMD_LOAD) begin
      shadow_gear[idx] = val;
      return 0;
    end
    if (p != 0 && p >= shadow_cfg.max_size) begin
      cut = 1'b1;
    end else if (p >= POS_W'(shadow_cfg.min_size)) begin
      m = (p < shadow_cfg.normal_size) ? shadow_cfg.mask_strict : shadow_cfg.mask_loose;
      shadow_fp = (shadow_fp << 1) + shadow_gear[dbyte];
      if (p != 0 && (shadow_fp & m) == 64'd0) cut = 1'b1;
    end
    // Close the chunk before this byte; the byte opens the next one
    if (cut) begin
      outs[n] = '{length: p, last: 1'b0};
      n++;
      p = '0;
      shadow_fp = (shadow_cfg.min_size == 16'd0) ? shadow_gear[dbyte] : 64'd0;
    end
    if (p != POS_CAP) p++;
    if (eod) begin
      outs[n] = '{length: p, last: 1'b1};
      n++;
      p = '0;
      shadow_fp = 64'd0;
    end
    shadow_pos = p;
    r0 = outs[0];
    r1 = outs[1];
    return n;
  endfunction

  function automatic logic [63:0] sparse_mask(input int bits);
    logic [63:0] m;
    m = '0;
    repeat (bits) m[$urandom_range(0, 63)] = 1'b1;
    return m;
  endfunction

  function automatic void add_cfg(input cfg_reg_t r, input logic [63:0] v);
    dir_row_t row;
    row.kind = ROW_CFG;
    row.reg_idx = r;
    row.reg_val = v;
    dir_rows.push_back(row);
  endfunction

  function automatic void add_item(input logic cmd, input logic [7:0] idx,
                                   input logic [63:0] val, input logic [7:0] dbyte,
                                   input logic eod, input int n_typed,
                                   input result_t t0, input result_t t1);
    dir_row_t row;
    row.kind = ROW_ITEM;
    row.cmd = cmd;
    row.idx = idx;
    row.val = val;
    row.dbyte = dbyte;
    row.eod = eod;
    row.n_typed = n_typed;
    row.typed0 = t0;
    row.typed1 = t1;
    dir_rows.push_back(row);
  endfunction

  // Write one register and mirror it in the shadow copy
  task automatic set_reg(input cfg_reg_t r, input logic [63:0] v);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= r;
    cfg_data  <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    case (r)
      REG_MIN_SIZE:    shadow_cfg.min_size    = v[15:0];
      REG_NORMAL_SIZE: shadow_cfg.normal_size = v[POS_W-1:0];
      REG_MAX_SIZE:    shadow_cfg.max_size    = v[POS_W-1:0];
      REG_MASK_STRICT: shadow_cfg.mask_strict = v;
      REG_MASK_LOOSE:  shadow_cfg.mask_loose  = v;
      default: ;
    endcase
  endtask

  // Drop valid, drain every expected chunk, then let the pipeline empty
  task automatic settle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_chunks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Offer one transfer in bursts with random gaps; queue its chunks on acceptance
  task automatic send_item(input logic cmd, input logic [7:0] idx, input logic [63:0] val,
                           input logic [7:0] dbyte, input logic eod, input int n_typed,
                           input result_t t0, input result_t t1);
    int      gap;
    int      n;
    result_t r0;
    result_t r1;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        s_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tlast  <= eod;
    s_tdata  <= {dbyte, val, idx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    burst_left--;
    n = gear_cut_step(cmd, idx, val, dbyte, eod, r0, r1);
    if (n_typed >= 0) begin
      n = n_typed;
      r0 = t0;
      r1 = t1;
    end
    if (n > 0) pending_chunks.push_back(r0);
    if (n > 1) pending_chunks.push_back(r1);
  endtask

  // Receiver: alternate ready patterns, with one long hold-off on request
  initial begin : chunk_sink
    int mode;
    int len;
    m_tready = 1'b0;
    forever begin
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        @(negedge clk);
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      mode = $urandom_range(0, 3);
      len = $urandom_range(20, 200);
      for (int i = 0; i < len && !(hold_req && !hold_done); i++) begin
        @(negedge clk);
        case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= 1'($urandom_range(0, 1));
          2: m_tready <= ($urandom_range(0, 3) == 0);
          default: m_tready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // Compare each chunk transfer with the oldest expectation
  always @(posedge clk) begin : chunk_check
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_chunks.size() == 0) begin
        $error("unexpected chunk: chunk_length %0d final_chunk %0b",
               m_tdata[POS_W-1:0], m_tlast);
        errors++;
      end else begin
        want = pending_chunks.pop_front();
        if (m_tdata[POS_W-1:0] !== want.length) begin
          $error("chunk_length: expected %0d, got %0d", want.length, m_tdata[POS_W-1:0]);
          errors++;
        end
        if (m_tlast !== want.last) begin
          $error("final_chunk: expected %0b, got %0b", want.last, m_tlast);
          errors++;
        end
      end
    end
  end

  // Watchdog: end the run after too many cycles without any transfer
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL normalized_gear_chunker");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [63:0] gv;
    logic        cmd;
    logic        eod;
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_index = REG_MIN_SIZE;
    cfg_data = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = CMD_LOAD;
    s_tlast = 1'b0;
    shadow_fp = '0;
    shadow_pos = '0;
    shadow_cfg.min_size    = MIN_SIZE_RST;
    shadow_cfg.normal_size = NORMAL_SIZE_RST;
    shadow_cfg.max_size    = MAX_SIZE_RST;
    shadow_cfg.mask_strict = MASK_STRICT_RST;
    shadow_cfg.mask_loose  = MASK_LOOSE_RST;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Fill the whole gear table; entry 0 is zero, entry 255 all ones
    for (int i = 0; i < 256; i++) begin
      gv = (i == 0) ? 64'd0 : (i == 255) ? '1 : {$urandom, $urandom};
      send_item(CMD_LOAD, 8'(i), gv, 8'($urandom), 1'($urandom_range(0, 1)), -1, '0, '0);
    end

    // Register defaults: no hashing this early, only end-of-stream chunks
    add_item(CMD_DATA, 8'h00, '0, 8'h00, 1'b1, 1, '{17'd1, 1'b1}, '0);
    add_item(CMD_DATA, 8'hFF, '1, 8'hFF, 1'b0, 0, '0, '0);
    add_item(CMD_DATA, 8'h00, '0, 8'h5A, 1'b1, 1, '{17'd2, 1'b1}, '0);
    // Zero max_size behaves as one; cut and end on the same byte
    add_cfg(REG_MAX_SIZE, 64'd0);
    add_item(CMD_DATA, 8'h00, '0, 8'h01, 1'b0, 0, '0, '0);
    add_item(CMD_DATA, 8'h00, '0, 8'h02, 1'b1, 2, '{17'd1, 1'b0}, '{17'd1, 1'b1});
    // Zero min_size and loose mask zero: every hashed byte past the first cuts
    add_cfg(REG_MIN_SIZE, 64'd0);
    add_cfg(REG_NORMAL_SIZE, 64'd0);
    add_cfg(REG_MASK_LOOSE, 64'd0);
    add_cfg(REG_MAX_SIZE, 64'd65536);
    add_item(CMD_DATA, 8'h00, '0, 8'h10, 1'b0, 0, '0, '0);
    add_item(CMD_DATA, 8'h00, '0, 8'h20, 1'b0, 1, '{17'd1, 1'b0}, '0);
    add_item(CMD_DATA, 8'h00, '0, 8'h30, 1'b1, 2, '{17'd1, 1'b0}, '{17'd1, 1'b1});
    // Loose mask all ones: cut only on a zero fingerprint (gear entry 0)
    add_cfg(REG_MASK_LOOSE, '1);
    add_item(CMD_LOAD, 8'hFF, '1, 8'hFF, 1'b1, 0, '0, '0);
    add_item(CMD_DATA, 8'h00, '0, 8'h00, 1'b0, 0, '0, '0);
    add_item(CMD_DATA, 8'h00, '0, 8'h00, 1'b0, 1, '{17'd1, 1'b0}, '0);
    add_item(CMD_DATA, 8'h00, '0, 8'hFF, 1'b1, 1, '{17'd2, 1'b1}, '0);
    // Largest sizes and strict mask all ones
    add_cfg(REG_MIN_SIZE, 64'd65535);
    add_cfg(REG_NORMAL_SIZE, 64'd65536);
    add_cfg(REG_MASK_STRICT, '1);
    add_item(CMD_DATA, 8'h00, '0, 8'h7F, 1'b1, 1, '{17'd1, 1'b1}, '0);
    // max_size of one forces a cut before every byte past the first
    add_cfg(REG_MAX_SIZE, 64'd1);
    add_item(CMD_DATA, 8'h00, '0, 8'h33, 1'b0, 0, '0, '0);
    add_item(CMD_DATA, 8'h00, '0, 8'h44, 1'b0, 1, '{17'd1, 1'b0}, '0);
    add_item(CMD_DATA, 8'h00, '0, 8'h55, 1'b1, 2, '{17'd1, 1'b0}, '{17'd1, 1'b1});
    // Small sizes with sparse masks, checked by the predictor
    add_cfg(REG_MIN_SIZE, 64'd2);
    add_cfg(REG_NORMAL_SIZE, 64'd4);
    add_cfg(REG_MAX_SIZE, 64'd8);
    add_cfg(REG_MASK_STRICT, 64'h8000_0000_0000_0101);
    add_cfg(REG_MASK_LOOSE, 64'h0000_0000_0000_0010);
    for (int i = 0; i < 8; i++)
      add_item(CMD_DATA, 8'h00, '0, 8'(8'h11 * i + 8'h07), i == 7, -1, '0, '0);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        settle();
        set_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
      end else begin
        send_item(dir_rows[i].cmd, dir_rows[i].idx, dir_rows[i].val, dir_rows[i].dbyte,
                  dir_rows[i].eod, dir_rows[i].n_typed, dir_rows[i].typed0,
                  dir_rows[i].typed1);
      end
    end

    // Random phases; the receiver holds off once near the start
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      gv = 64'($urandom_range(0, 6));
      set_reg(REG_MIN_SIZE, gv);
      case ($urandom_range(0, 4))
        0:       set_reg(REG_NORMAL_SIZE, 64'd0);
        1:       set_reg(REG_NORMAL_SIZE, 64'd65536);
        default: set_reg(REG_NORMAL_SIZE, gv + 64'($urandom_range(0, 12)));
      endcase
      case ($urandom_range(0, 5))
        0:       set_reg(REG_MAX_SIZE, 64'd0);
        1:       set_reg(REG_MAX_SIZE, 64'd65536);
        default: set_reg(REG_MAX_SIZE, 64'($urandom_range(1, 30)));
      endcase
      set_reg(REG_MASK_STRICT, sparse_mask($urandom_range(1, 4)));
      set_reg(REG_MASK_LOOSE, sparse_mask($urandom_range(0, 2)));
      // Start the hold-off while the sender keeps offering transfers
      if (ph == 0) hold_req = 1'b1;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        cmd = ($urandom_range(0, 11) == 0) ? CMD_LOAD : CMD_DATA;
        eod = ($urandom_range(0, 24) == 0);
        send_item(cmd, 8'($urandom), {$urandom, $urandom}, 8'($urandom), eod, -1, '0, '0);
      end
    end

    settle();
    if (errors == 0 && pending_chunks.size() == 0) begin
      $display("PASS normalized_gear_chunker");
    end else begin
      $display("FAIL normalized_gear_chunker");
    end
    $finish;
  end

endmodule
